// ----- src/lgps_pkg.sv -----
package lgps_pkg;

	localparam int AXIS_W          = 16;
	localparam int Y_RAW_W         = 8;
	localparam int LEN_W           = 7;
	localparam int BYTE_W          = 8;
	localparam int TRIGGER_BIT     = 5;
	localparam int DIV_STEPS       = AXIS_W;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
	localparam int IN_TDATA_W      = 40;
	localparam int OUT_TDATA_W     = 40;
	localparam int CFG_INDEX_W     = 8;

	localparam logic [AXIS_W-1:0] AXIS_FULL_SCALE = 16'hFFFF;
	localparam logic [LEN_W-1:0]  REPORT_SIZE     = 7'd6;

	localparam logic [AXIS_W-1:0] X_LOW_RESET  = 16'd80;
	localparam logic [AXIS_W-1:0] X_HIGH_RESET = 16'd734;
	localparam logic [AXIS_W-1:0] Y_LOW_RESET  = 16'd0;
	localparam logic [AXIS_W-1:0] Y_HIGH_RESET = 16'd240;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_X_LOW  = 8'd0,
		REG_X_HIGH = 8'd1,
		REG_Y_LOW  = 8'd2,
		REG_Y_HIGH = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [AXIS_W-1:0] x_low;
		logic [AXIS_W-1:0] x_high;
		logic [AXIS_W-1:0] y_low;
		logic [AXIS_W-1:0] y_high;
	} window_t;

	// one axis as classified by the front end
	typedef struct packed {
		logic [AXIS_W-1:0] offset;
		logic [AXIS_W-1:0] span;
	} axis_job_t;

	typedef struct packed {
		logic      trigger;
		logic      off;
		axis_job_t x;
		axis_job_t y;
	} job_t;

	// restoring divider lane: partial remainder, unconsumed dividend bits, quotient so far
	typedef struct packed {
		logic [AXIS_W-1:0] rem;
		logic [AXIS_W-1:0] low;
		logic [AXIS_W-1:0] quo;
		logic [AXIS_W-1:0] span;
	} div_lane_t;

	typedef struct packed {
		logic      trigger;
		logic      off;
		div_lane_t x;
		div_lane_t y;
	} div_item_t;

	// dividend = offset * full scale; top half is already below span for on-screen points
	function automatic div_lane_t div_load(axis_job_t a);
		logic [2*AXIS_W-1:0] prod;
		div_lane_t           l;
		prod   = {{AXIS_W{1'b0}}, a.offset} * {{AXIS_W{1'b0}}, AXIS_FULL_SCALE};
		l.rem  = prod[2*AXIS_W-1:AXIS_W];
		l.low  = prod[AXIS_W-1:0];
		l.quo  = '0;
		l.span = a.span;
		return l;
	endfunction

	function automatic div_lane_t div_step(div_lane_t l);
		logic [AXIS_W:0] t;
		logic [AXIS_W:0] diff;
		div_lane_t       r;
		t      = {l.rem, l.low[AXIS_W-1]};
		diff   = t - {1'b0, l.span};
		r      = l;
		r.low  = {l.low[AXIS_W-2:0], 1'b0};
		if (t >= {1'b0, l.span}) begin
			r.rem = diff[AXIS_W-1:0];
			r.quo = {l.quo[AXIS_W-2:0], 1'b1};
		end else begin
			r.rem = t[AXIS_W-1:0];
			r.quo = {l.quo[AXIS_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ----- src/lgps_front.sv -----
module lgps_front (
	input  logic                             transfer_ok,
	input  logic [lgps_pkg::LEN_W-1:0]       report_length,
	input  logic [lgps_pkg::BYTE_W-1:0]      button_byte,
	input  logic [lgps_pkg::BYTE_W-1:0]      x_low_byte,
	input  logic [lgps_pkg::BYTE_W-1:0]      x_high_byte,
	input  logic [lgps_pkg::BYTE_W-1:0]      y_byte,
	input  lgps_pkg::window_t                win,
	output logic                             keep,
	output lgps_pkg::job_t                   job
);
	import lgps_pkg::*;

	logic [AXIS_W-1:0] raw_x;
	logic [AXIS_W-1:0] raw_y;

	assign raw_x = {x_high_byte, x_low_byte};
	assign raw_y = {{(AXIS_W-Y_RAW_W){1'b0}}, y_byte};

	assign keep = transfer_ok && (report_length == REPORT_SIZE);

	always_comb begin
		job.trigger  = ~button_byte[TRIGGER_BIT];
		job.off      = (raw_x < win.x_low) || (raw_x > win.x_high) ||
		               (raw_y < win.y_low) || (raw_y > win.y_high);
		job.x.offset = raw_x - win.x_low;
		job.x.span   = win.x_high - win.x_low;
		job.y.offset = raw_y - win.y_low;
		job.y.span   = win.y_high - win.y_low;
	end

endmodule

// ----- src/lgps_queue.sv -----
module lgps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lgps_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output lgps_pkg::job_t  head_job
);
	import lgps_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (cnt_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- src/lgps_back.sv -----
module lgps_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_avail,
	input  lgps_pkg::job_t                       job,
	output logic                                 job_pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [lgps_pkg::OUT_TDATA_W-1:0]     m_tdata,  // trigger_pressed, scaled_x, scaled_y, pad
	output logic                                 m_tuser   // off_screen
);
	import lgps_pkg::*;

	// index 0 holds the loaded dividend, index k the item after k divide steps
	div_item_t         stage_s [DIV_STEPS+1];
	logic              vld_s   [DIV_STEPS+1];
	logic              out_vld_q;
	logic              out_trig_q;
	logic              out_off_q;
	logic [AXIS_W-1:0] out_x_q;
	logic [AXIS_W-1:0] out_y_q;
	logic              adv;
	div_item_t         last;

	assign adv     = !out_vld_q || m_tready;
	assign job_pop = adv && job_avail;
	assign last    = stage_s[DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++)
				vld_s[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= job_avail;
			for (int i = 1; i <= DIV_STEPS; i++)
				vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s[0].trigger <= job.trigger;
			stage_s[0].off     <= job.off;
			stage_s[0].x       <= div_load(job.x);
			stage_s[0].y       <= div_load(job.y);
			for (int i = 1; i <= DIV_STEPS; i++) begin
				stage_s[i].trigger <= stage_s[i-1].trigger;
				stage_s[i].off     <= stage_s[i-1].off;
				stage_s[i].x       <= div_step(stage_s[i-1].x);
				stage_s[i].y       <= div_step(stage_s[i-1].y);
			end
			out_trig_q <= last.trigger;
			out_off_q  <= last.off;
			if (last.off) begin
				out_x_q <= '0;
				out_y_q <= '0;
			end else begin
				out_x_q <= (last.x.span == '0) ? AXIS_FULL_SCALE : last.x.quo;
				out_y_q <= (last.y.span == '0) ? AXIS_FULL_SCALE : last.y.quo;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_off_q;
	assign m_tdata  = {{(OUT_TDATA_W-2*AXIS_W-1){1'b0}}, out_y_q, out_x_q, out_trig_q};

`ifndef ASSERT_OFF
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_off_q |-> (out_x_q == '0) && (out_y_q == '0))
		else $error("off-screen word with nonzero position");

	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STEPS] && !last.off && (last.x.span != '0) |-> last.x.rem < last.x.span)
		else $error("x remainder not below span");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STEPS] && !last.off && (last.y.span != '0) |-> last.y.rem < last.y.span)
		else $error("y remainder not below span");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> vld_s[0])
		else $error("popped word did not enter the divider");
`endif

endmodule

// ----- src/light_gun_position_scaler.sv -----
// Throughput: one report per cycle unless m_tready stalls the output; the divider
// is a 16-stage restoring pipeline (one quotient bit per stage) fed from a 4-word
// queue behind the classifier.
// Reports that fail the transfer or length check are taken and produce no word.
// arst_n clears all valid state and loads the window registers with 80/734/0/240.
module light_gun_position_scaler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// report_length, button_byte, x_low_byte, x_high_byte, y_byte, pad
	input  logic [lgps_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                  s_tuser,   // transfer_ok
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// trigger_pressed, scaled_x, scaled_y, pad
	output logic [lgps_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tuser,   // off_screen
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lgps_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lgps_pkg::AXIS_W-1:0]           cfg_data
);
	import lgps_pkg::*;

	window_t win_q;
	logic    keep;
	job_t    job;
	job_t    head_job;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	logic    push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.x_low  <= X_LOW_RESET;
			win_q.x_high <= X_HIGH_RESET;
			win_q.y_low  <= Y_LOW_RESET;
			win_q.y_high <= Y_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_LOW:  win_q.x_low  <= cfg_data;
				REG_X_HIGH: win_q.x_high <= cfg_data;
				REG_Y_LOW:  win_q.y_low  <= cfg_data;
				REG_Y_HIGH: win_q.y_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lgps_front u_front (
		.transfer_ok   (s_tuser),
		.report_length (s_tdata[6:0]),
		.button_byte   (s_tdata[14:7]),
		.x_low_byte    (s_tdata[22:15]),
		.x_high_byte   (s_tdata[30:23]),
		.y_byte        (s_tdata[38:31]),
		.win           (win_q),
		.keep          (keep),
		.job           (job)
	);

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready && keep;

	lgps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	lgps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!q_empty),
		.job       (head_job),
		.job_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
